// File: src/lphs_pkg.sv
package lphs_pkg;

    localparam int TABLE_SIZE = 8;
    localparam int SLOT_W     = $clog2(TABLE_SIZE);
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
    localparam int KEY_W      = 31;
    localparam int CMDQ_DEPTH = 2;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_LOOKUP = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        STAT_OK    = 3'd0,
        STAT_DUP   = 3'd1,
        STAT_FULL  = 3'd2,
        STAT_MISS  = 3'd3,
        STAT_EMPTY = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_USED    = 2'd1,
        MARK_DELETED = 2'd2
    } mark_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_PROBE,
        ENG_FINISH
    } eng_state_t;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [KEY_W-1:0] key;
    } request_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  entries;
    } result_t;

    // Classified request handed from the front queue to the probe engine.
    typedef struct packed {
        req_t              op;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] home;
    } cmd_t;

endpackage

// File: src/linear_probe_hash_set_top.sv
// Hash set of 31-bit keys in TABLE_SIZE slots with linear probing and tombstones.
// Requests go in through a two-entry command queue; results come out of a one-entry
// output register, so a new request is taken while an earlier result waits to be
// popped. The probe engine handles one request at a time and walks one slot per
// cycle from the home slot (key modulo TABLE_SIZE). A request is taken in idle,
// probes 1 to TABLE_SIZE slots in probe and posts its result from finish, which
// waits while an earlier result is unpopped. An insert into a full table and a
// delete on an empty one skip probe. All slots are empty after reset.
module linear_probe_hash_set_top
    import lphs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  request_t request,
    output logic     empty,
    input  logic     pop,
    output result_t  result
);

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    lphs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    lphs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

`ifndef SYNTHESIS
    a_entries_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.entries <= CNT_W'(TABLE_SIZE))
        else $error("live count exceeds the table size");

    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status != STAT_OK) |-> result.slot == '0)
        else $error("failed request reports a nonzero slot");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status == STAT_FULL) |-> result.entries == CNT_W'(TABLE_SIZE))
        else $error("insert refused while the table has room");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status == STAT_EMPTY) |-> result.entries == '0)
        else $error("table reported empty while keys are live");
`endif

endmodule

// File: src/lphs_front.sv
module lphs_front
    import lphs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  request_t request,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_pop
);

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int QCNT_W = $clog2(CMDQ_DEPTH + 1);

    cmd_t              queue_reg [CMDQ_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    cmd_t              classified;
    logic              do_push;
    logic              do_pop;

    // Unused request code 3 behaves as a lookup.
    always_comb
    begin
        unique case (request.req_type)
            REQ_INSERT: classified.op = REQ_INSERT;
            REQ_DELETE: classified.op = REQ_DELETE;
            default:    classified.op = REQ_LOOKUP;
        endcase
        classified.key  = request.key;
        classified.home = SLOT_W'(request.key % TABLE_SIZE);
    end

    assign full      = (count_reg == QCNT_W'(CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            queue_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

// File: src/lphs_back.sv
module lphs_back
    import lphs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    eng_state_t        state_reg, state_next;
    req_t              op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [SLOT_W-1:0] ptr_reg, ptr_next;
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    logic              have_free_reg, have_free_next;
    logic [SLOT_W-1:0] free_slot_reg, free_slot_next;
    result_t           res_reg, res_next;
    logic [CNT_W-1:0]  live_reg, live_next;
    result_t           out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    mark_t             mark_reg [TABLE_SIZE];
    logic [KEY_W-1:0]  key_mem [TABLE_SIZE];

    mark_t             cur_mark;
    logic              hit;
    logic              stop;
    logic              free_here;
    logic [SLOT_W-1:0] ins_slot;
    logic              mark_we;
    logic [SLOT_W-1:0] mark_sel;
    mark_t             mark_val;
    logic              key_we;

    assign cur_mark  = mark_reg[ptr_reg];
    assign hit       = (cur_mark == MARK_USED) && (key_mem[ptr_reg] == key_reg);
    assign stop      = (cur_mark == MARK_EMPTY) || hit || (cnt_reg == SLOT_W'(TABLE_SIZE - 1));
    assign free_here = (cur_mark != MARK_USED);
    assign ins_slot  = have_free_reg ? free_slot_reg : ptr_reg;
    assign empty     = !out_valid_reg;
    assign result    = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        have_free_next = have_free_reg;
        free_slot_next = free_slot_reg;
        res_next       = res_reg;
        live_next      = live_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        cmd_pop        = 1'b0;
        mark_we        = 1'b0;
        mark_sel       = ptr_reg;
        mark_val       = MARK_USED;
        key_we         = 1'b0;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ENG_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop        = 1'b1;
                    op_next        = cmd.op;
                    key_next       = cmd.key;
                    ptr_next       = cmd.home;
                    cnt_next       = '0;
                    have_free_next = 1'b0;
                    // A full table refuses an insert, and an empty one a delete,
                    // before any slot is probed.
                    if (cmd.op == REQ_INSERT && live_reg >= CNT_W'(TABLE_SIZE))
                    begin
                        res_next   = '{STAT_FULL, '0, live_reg};
                        state_next = ENG_FINISH;
                    end
                    else if (cmd.op == REQ_DELETE && live_reg == '0)
                    begin
                        res_next   = '{STAT_EMPTY, '0, live_reg};
                        state_next = ENG_FINISH;
                    end
                    else
                    begin
                        state_next = ENG_PROBE;
                    end
                end
            end
            ENG_PROBE:
            begin
                // The first slot not in use along the probe is where an insert lands.
                if (free_here && !have_free_reg)
                begin
                    have_free_next = 1'b1;
                    free_slot_next = ptr_reg;
                end
                if (stop)
                begin
                    state_next = ENG_FINISH;
                    unique case (op_reg)
                        REQ_INSERT:
                        begin
                            if (hit)
                            begin
                                res_next = '{STAT_DUP, '0, live_reg};
                            end
                            else if (have_free_reg || free_here)
                            begin
                                key_we    = 1'b1;
                                mark_we   = 1'b1;
                                mark_sel  = ins_slot;
                                mark_val  = MARK_USED;
                                live_next = live_reg + 1'b1;
                                res_next  = '{STAT_OK, ins_slot, live_reg + 1'b1};
                            end
                            else
                            begin
                                res_next = '{STAT_FULL, '0, live_reg};
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (hit)
                            begin
                                mark_we   = 1'b1;
                                mark_sel  = ptr_reg;
                                mark_val  = MARK_DELETED;
                                live_next = live_reg - 1'b1;
                                res_next  = '{STAT_OK, ptr_reg, live_reg - 1'b1};
                            end
                            else
                            begin
                                res_next = '{STAT_MISS, '0, live_reg};
                            end
                        end
                        default:
                        begin
                            if (hit)
                            begin
                                res_next = '{STAT_OK, ptr_reg, live_reg};
                            end
                            else
                            begin
                                res_next = '{STAT_MISS, '0, live_reg};
                            end
                        end
                    endcase
                end
                else
                begin
                    ptr_next = (ptr_reg == SLOT_W'(TABLE_SIZE - 1)) ? '0 : ptr_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ENG_FINISH:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ENG_IDLE;
                end
            end
            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ENG_IDLE;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                mark_reg[i] <= MARK_EMPTY;
            end
        end
        else
        begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
            if (mark_we)
            begin
                mark_reg[mark_sel] <= mark_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        ptr_reg       <= ptr_next;
        cnt_reg       <= cnt_next;
        have_free_reg <= have_free_next;
        free_slot_reg <= free_slot_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
        if (key_we)
        begin
            key_mem[ins_slot] <= key_reg;
        end
    end

endmodule

// File: sim/tb_linear_probe_hash_set_top.sv
`timescale 1ns / 100ps

module tb_linear_probe_hash_set_top;
    import lphs_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_ITEMS = 300;
    localparam int BURST_LEN    = 50;
    localparam int POOL_SIZE    = 12;
    localparam int PRINT_LIMIT  = 50;

    // Request code that the block handles as a lookup.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic     clk     = 1'b0;
    logic     rst_n   = 1'b0;
    logic     push    = 1'b0;
    logic     full;
    request_t request = '0;
    logic     empty;
    logic     pop     = 1'b0;
    result_t  result;

    // Shadow copy of the set, updated as each request transfer is accepted.
    logic [KEY_W-1:0] shadow_key  [TABLE_SIZE] = '{default: '0};
    mark_t            shadow_mark [TABLE_SIZE] = '{default: MARK_EMPTY};
    int unsigned      shadow_live = 0;

    result_t          pending_results[$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    int unsigned send_idle_pct = 0;
    int unsigned pop_stall_pct = 0;
    int unsigned mismatches    = 0;
    int unsigned requests_sent = 0;
    int unsigned results_seen  = 0;
    int unsigned idle_cycles   = 0;
    int unsigned status_seen [8] = '{default: 0};

    linear_probe_hash_set_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
        begin
            $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    function automatic result_t predict_result(input request_t rq);
        result_t           res;
        logic [SLOT_W-1:0] home;
        logic [SLOT_W-1:0] probe;
        logic [SLOT_W-1:0] hit;
        logic              found;
        logic              stop;
        logic              placed;
        int                n;

        res.status  = STAT_MISS;
        res.slot    = '0;
        hit         = '0;
        found       = 1'b0;
        stop        = 1'b0;
        placed      = 1'b0;
        home        = SLOT_W'(rq.key % TABLE_SIZE);

        // The search passes tombstones and other keys; only an empty slot, a matching
        // key or a full lap ends it.
        probe = home;
        for (n = 0; n < TABLE_SIZE; n++)
        begin
            if (!stop)
            begin
                if (shadow_mark[probe] == MARK_EMPTY)
                begin
                    stop = 1'b1;
                end
                else if (shadow_mark[probe] == MARK_USED && shadow_key[probe] == rq.key)
                begin
                    found = 1'b1;
                    hit   = probe;
                    stop  = 1'b1;
                end
                probe = SLOT_W'((probe + 1) % TABLE_SIZE);
            end
        end

        case (rq.req_type)
            REQ_INSERT:
            begin
                if (shadow_live >= TABLE_SIZE)
                begin
                    res.status = STAT_FULL;
                end
                else if (found)
                begin
                    res.status = STAT_DUP;
                end
                else
                begin
                    res.status = STAT_FULL;
                    probe      = home;
                    for (n = 0; n < TABLE_SIZE; n++)
                    begin
                        if (!placed && shadow_mark[probe] != MARK_USED)
                        begin
                            shadow_key[probe]  = rq.key;
                            shadow_mark[probe] = MARK_USED;
                            shadow_live++;
                            placed     = 1'b1;
                            res.status = STAT_OK;
                            res.slot   = probe;
                        end
                        probe = SLOT_W'((probe + 1) % TABLE_SIZE);
                    end
                end
            end
            REQ_DELETE:
            begin
                if (shadow_live == 0)
                begin
                    res.status = STAT_EMPTY;
                end
                else if (found)
                begin
                    shadow_mark[hit] = MARK_DELETED;
                    shadow_live--;
                    res.status = STAT_OK;
                    res.slot   = hit;
                end
            end
            default:
            begin
                if (found)
                begin
                    res.status = STAT_OK;
                    res.slot   = hit;
                end
            end
        endcase

        res.entries = CNT_W'(shadow_live);
        status_seen[int'(res.status)]++;
        return res;
    endfunction

    // Request and result transfers are both sampled here, on pre-edge values.
    always @(posedge clk)
    begin
        result_t want;

        if (rst_n)
        begin
            if (push && !full)
            begin
                pending_results.push_back(predict_result(request));
                requests_sent++;
            end
            if (pop && !empty)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unrequested result, status", result.status, 0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.status !== want.status)
                    begin
                        report_mismatch("status", result.status, want.status);
                    end
                    if (result.slot !== want.slot)
                    begin
                        report_mismatch("slot", result.slot, want.slot);
                    end
                    if (result.entries !== want.entries)
                    begin
                        report_mismatch("entries", result.entries, want.entries);
                    end
                end
            end
        end
        pop <= (pop_stall_pct == 0) || ($urandom_range(99) >= pop_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("No transfer in %0d cycles, giving up", IDLE_LIMIT);
            $display("FAIL linear_probe_hash_set_top");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] kind, input logic [KEY_W-1:0] key_val);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        request <= '{req_type: kind, key: key_val};
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_empty_set();
        send_request(REQ_LOOKUP, 31'd5);
        send_request(REQ_DELETE, 31'd5);
        send_request(REQ_UNUSED, 31'd0);
    endtask

    // Keys sharing a home slot build a cluster; deleting its middle leaves a
    // tombstone that later searches must step over and inserts may reuse.
    task automatic test_collisions();
        send_request(REQ_INSERT, 31'd0);
        send_request(REQ_INSERT, 31'd8);
        send_request(REQ_INSERT, 31'd16);
        send_request(REQ_INSERT, 31'd0);
        send_request(REQ_LOOKUP, 31'd16);
        send_request(REQ_DELETE, 31'd8);
        send_request(REQ_LOOKUP, 31'd16);
        send_request(REQ_DELETE, 31'd8);
        send_request(REQ_INSERT, 31'd24);
        send_request(REQ_INSERT, 31'h7FFF_FFFF);
        send_request(REQ_INSERT, 31'h7FFF_FFF7);
        send_request(REQ_UNUSED, 31'h7FFF_FFF7);
    endtask

    task automatic test_full_set();
        send_request(REQ_INSERT, 31'd4);
        send_request(REQ_INSERT, 31'd5);
        send_request(REQ_INSERT, 31'd6);
        send_request(REQ_INSERT, 31'h4000_0000);
        send_request(REQ_INSERT, 31'd0);
        send_request(REQ_LOOKUP, 31'd1);
        send_request(REQ_DELETE, 31'd4);
        send_request(REQ_LOOKUP, 31'd12);
        send_request(REQ_DELETE, 31'd12);
        send_request(REQ_INSERT, 31'd12);
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
        int unsigned      insert_pct;
        int unsigned      pick;
        int               i;
        logic [1:0]       kind;
        logic [KEY_W-1:0] key_val;

        send_idle_pct = idle_pct;
        pop_stall_pct = stall_pct;

        // A small pool of keys, about half of them forced into shared home slots,
        // keeps hits, duplicates and long probe chains frequent.
        for (i = 0; i < POOL_SIZE; i++)
        begin
            key_pool[i] = KEY_W'($urandom());
            if ($urandom_range(1) == 1)
            begin
                key_pool[i][SLOT_W-1:0] = SLOT_W'(i % 3);
            end
        end

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            // Alternate insert-heavy and delete-heavy bursts so the set fills and drains.
            insert_pct = ((i / BURST_LEN) % 2 == 0) ? 65 : 20;
            pick       = $urandom_range(99);
            if (pick < insert_pct)
            begin
                kind = REQ_INSERT;
            end
            else if (pick < 95)
            begin
                kind = ($urandom_range(1) == 1) ? REQ_DELETE : REQ_LOOKUP;
            end
            else
            begin
                kind = REQ_UNUSED;
            end
            if ($urandom_range(99) < 85)
            begin
                key_val = key_pool[$urandom_range(POOL_SIZE - 1)];
            end
            else
            begin
                key_val = KEY_W'($urandom());
            end
            send_request(kind, key_val);
        end
    endtask

    initial
    begin
        repeat (8)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_set();
        test_collisions();
        test_full_set();
        test_random_traffic(0, 0);
        test_random_traffic(67, 0);
        test_random_traffic(0, 67);
        test_random_traffic(25, 25);

        push <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TABLE_SIZE + 4)
        begin
            @(posedge clk);
        end

        $display("Sent %0d requests and checked %0d results across four idle/stall mixes.",
                 requests_sent, results_seen);
        $display("Outcomes: %0d ok, %0d duplicate, %0d full, %0d not found, %0d empty set.",
                 status_seen[STAT_OK], status_seen[STAT_DUP], status_seen[STAT_FULL],
                 status_seen[STAT_MISS], status_seen[STAT_EMPTY]);
        if (mismatches == 0)
        begin
            $display("PASS linear_probe_hash_set_top");
        end
        else
        begin
            $display("%0d mismatches found", mismatches);
            $display("FAIL linear_probe_hash_set_top");
        end
        $finish;
    end

endmodule

// File: sim.f
src/lphs_pkg.sv
src/lphs_front.sv
src/lphs_back.sv
src/linear_probe_hash_set_top.sv
sim/tb_linear_probe_hash_set_top.sv
